// ----- hdl/slipr_pkg.sv -----
`default_nettype none

package slipr_pkg;

    // Largest frame in decoded bytes; widths below follow from it.
    localparam int MaxFrameBytes = 2048;
    localparam int CountW        = $clog2(MaxFrameBytes + 1);
    localparam int PosW          = $clog2(MaxFrameBytes);

    // Fixed field widths of the result word
    localparam int FrameLenW = 12;
    localparam int PosOutW   = 11;
    localparam int IdleW     = 16;

    localparam logic [CountW-1:0] MinFrame = CountW'(3);
    localparam logic [IdleW-1:0]  IdleTimeoutReset = IdleW'(200);
    localparam logic [IdleW-1:0]  IdleMax = '1;

    // SLIP special characters
    localparam logic [7:0] SlipEnd    = 8'hC0;
    localparam logic [7:0] SlipEsc    = 8'hDB;
    localparam logic [7:0] SlipEscEnd = 8'hDC;
    localparam logic [7:0] SlipEscEsc = 8'hDD;

    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        EV_DATA     = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_DROP     = 2'd2
    } event_kind_t;

    typedef enum logic [1:0]
    {
        CAUSE_OVERRUN = 2'd0,
        CAUSE_RUNT    = 2'd1,
        CAUSE_IDLE    = 2'd2
    } drop_cause_t;

    typedef struct packed
    {
        event_kind_t          event_kind;
        logic [7:0]           data_byte;
        logic [PosOutW-1:0]   byte_position;
        logic [FrameLenW-1:0] frame_length;
        logic [7:0]           opcode;
        logic [15:0]          request_id;
        drop_cause_t          drop_cause;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/slipr_core.sv -----
`default_nettype none

// Frame state and per-word decode. State advances on fire.
module slipr_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire slipr_pkg::op_t                op,
    input  wire logic [7:0]                    rx_data,
    input  wire logic [slipr_pkg::IdleW-1:0]   timeout,
    output logic                               res_valid,
    output slipr_pkg::result_t                 res
);

    logic                            in_frame_reg, in_frame_next;
    logic                            esc_reg, esc_next;
    logic [slipr_pkg::CountW-1:0]    count_reg, count_next;
    logic [7:0]                      opcode_reg, opcode_next;
    logic [15:0]                     req_reg, req_next;
    logic [slipr_pkg::IdleW-1:0]     idle_reg, idle_next;

    always_comb
    begin
        logic [7:0] b;
        logic       take;

        b             = rx_data;
        take          = 1'b0;
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        opcode_next   = opcode_reg;
        req_next      = req_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        res           = '{event_kind: slipr_pkg::EV_DATA,
                          drop_cause: slipr_pkg::CAUSE_OVERRUN,
                          default: '0};

        unique case (op)
            slipr_pkg::OP_TICK:
            begin
                if (idle_reg != slipr_pkg::IdleMax)
                begin
                    idle_next = idle_reg + 1'b1;
                end
                if (in_frame_reg && (count_reg != '0) && (idle_next >= timeout))
                begin
                    res_valid          = 1'b1;
                    res.event_kind     = slipr_pkg::EV_DROP;
                    res.frame_length   = slipr_pkg::FrameLenW'(count_reg);
                    res.drop_cause     = slipr_pkg::CAUSE_IDLE;
                    in_frame_next      = 1'b0;
                    esc_next           = 1'b0;
                    count_next         = '0;
                    opcode_next        = '0;
                    req_next           = '0;
                end
            end
            slipr_pkg::OP_BYTE:
            begin
                idle_next = '0;
                if (rx_data == slipr_pkg::SlipEnd)
                begin
                    if (in_frame_reg && (count_reg != '0))
                    begin
                        res_valid        = 1'b1;
                        res.frame_length = slipr_pkg::FrameLenW'(count_reg);
                        if (count_reg < slipr_pkg::MinFrame)
                        begin
                            res.event_kind = slipr_pkg::EV_DROP;
                            res.drop_cause = slipr_pkg::CAUSE_RUNT;
                        end
                        else
                        begin
                            res.event_kind = slipr_pkg::EV_COMPLETE;
                            res.opcode     = opcode_reg;
                            res.request_id = req_reg;
                        end
                    end
                    in_frame_next = 1'b1;
                    esc_next      = 1'b0;
                    count_next    = '0;
                    opcode_next   = '0;
                    req_next      = '0;
                end
                else if (in_frame_reg)
                begin
                    if (esc_reg)
                    begin
                        if (rx_data == slipr_pkg::SlipEscEnd)
                        begin
                            b = slipr_pkg::SlipEnd;
                        end
                        else if (rx_data == slipr_pkg::SlipEscEsc)
                        begin
                            b = slipr_pkg::SlipEsc;
                        end
                        esc_next = 1'b0;
                        take     = 1'b1;
                    end
                    else if (rx_data == slipr_pkg::SlipEsc)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (take)
        begin
            res_valid = 1'b1;
            if (count_reg >= slipr_pkg::CountW'(slipr_pkg::MaxFrameBytes))
            begin
                // overrun: drop and wait for the next END
                res.event_kind   = slipr_pkg::EV_DROP;
                res.frame_length = slipr_pkg::FrameLenW'(count_reg);
                res.drop_cause   = slipr_pkg::CAUSE_OVERRUN;
                in_frame_next    = 1'b0;
                esc_next         = 1'b0;
                count_next       = '0;
                opcode_next      = '0;
                req_next         = '0;
            end
            else
            begin
                if (count_reg == slipr_pkg::CountW'(0))
                begin
                    opcode_next = b;
                end
                else if (count_reg == slipr_pkg::CountW'(1))
                begin
                    req_next = {req_reg[15:8], b};
                end
                else if (count_reg == slipr_pkg::CountW'(2))
                begin
                    req_next = {b, req_reg[7:0]};
                end
                res.event_kind    = slipr_pkg::EV_DATA;
                res.data_byte     = b;
                res.byte_position = slipr_pkg::PosOutW'(count_reg[slipr_pkg::PosW-1:0]);
                count_next        = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
            opcode_reg   <= '0;
            req_reg      <= '0;
            idle_reg     <= '0;
        end
        else if (fire)
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
            opcode_reg   <= opcode_next;
            req_reg      <= req_next;
            idle_reg     <= idle_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/slip_frame_receiver.sv -----
// SLIP frame receiver. Each input word is either a raw line byte (operation 0)
// or one time tick (operation 1). An END byte closes the open frame and opens
// a new one; bytes outside a frame are ignored, and ESC sequences are undone.
// Every decoded byte comes out as a data event with its position in the frame;
// a frame closed by END gives a complete event with its length, the first byte
// as opcode and bytes 1..2 as a little-endian request id, or a runt drop when
// it holds 1 or 2 bytes. An empty frame gives nothing. Overrun past 2048 bytes
// and an idle timeout (idle_timeout_ticks ticks with no byte) drop the frame
// and the receiver then waits for END. Throughput is one word per clock while
// the result output is not stalled; a word goes through an input register and
// a combinational decode of the frame state into the result register. The
// decode step reads and updates the frame state once per word. Write
// idle_timeout_ticks only while idle.
`default_nettype none

module slip_frame_receiver
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // config write channel (idle_timeout_ticks)
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,

    // input words
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  rx_byte,

    // result words
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       event_kind,
    output logic [7:0]       data_byte,
    output logic [10:0]      byte_position,
    output logic [11:0]      frame_length,
    output logic [7:0]       opcode,
    output logic [15:0]      request_id,
    output logic [1:0]       drop_cause
);

    logic [slipr_pkg::IdleW-1:0] timeout_reg;

    // input register
    logic             s1_valid_reg, s1_valid_next;
    slipr_pkg::op_t   s1_op_reg;
    logic [7:0]       s1_byte_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    slipr_pkg::result_t    out_res_reg;

    logic                  core_res_valid;
    slipr_pkg::result_t    core_res;
    logic                  slot_free;   // result register can take a word
    logic                  advance;     // word in the input register retires
    logic                  in_fire;

    assign cfg_ready = 1'b1;

    assign slot_free = !out_valid_reg || !out_stall;
    // a word without a result never waits on the output side
    assign advance   = s1_valid_reg && (!core_res_valid || slot_free);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_fire   = in_valid && !in_stall;

    assign s1_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (advance && core_res_valid) ? 1'b1
                          : (out_stall ? out_valid_reg : 1'b0);

    slipr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .op        (s1_op_reg),
        .rx_data   (s1_byte_reg),
        .timeout   (timeout_reg),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= slipr_pkg::IdleTimeoutReset;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg   <= slipr_pkg::op_t'(operation);
            s1_byte_reg <= rx_byte;
        end
        if (advance && core_res_valid)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_res_reg.event_kind;
    assign data_byte     = out_res_reg.data_byte;
    assign byte_position = out_res_reg.byte_position;
    assign frame_length  = out_res_reg.frame_length;
    assign opcode        = out_res_reg.opcode;
    assign request_id    = out_res_reg.request_id;
    assign drop_cause    = out_res_reg.drop_cause;

`ifndef ASSERT_OFF
    // an empty input register never holds off the sender
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    // a completed frame always carries at least the header bytes
    a_complete_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_res_reg.event_kind == slipr_pkg::EV_COMPLETE))
        |-> (frame_length >= slipr_pkg::FrameLenW'(slipr_pkg::MinFrame)))
        else $error("complete event with short frame");

    // runt drops hold one or two bytes
    a_runt_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_res_reg.event_kind == slipr_pkg::EV_DROP)
         && (out_res_reg.drop_cause == slipr_pkg::CAUSE_RUNT))
        |-> ((frame_length == 12'd1) || (frame_length == 12'd2)))
        else $error("runt drop with bad length");

    // config write lands in the timeout register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (timeout_reg == $past(cfg_data)))
        else $error("timeout register not updated");
`endif

endmodule

`default_nettype wire
